### rtl/phd_pkg.sv
`timescale 1ns / 1ps
package phd_pkg;

   localparam logic [15:0] HDR_LEN      = 16'd8;
   localparam logic [15:0] HDR_LAST     = 16'd7;
   localparam logic [15:0] MAGIC_END    = 16'd2;
   localparam logic [15:0] SIZE_END     = 16'd4;
   localparam logic [3:0]  KEY_BYTES    = 4'd4;
   localparam logic [3:0]  ID_BYTES     = 4'd8;
   localparam logic [7:0]  FLAG_KEY     = 8'h01;
   localparam logic [7:0]  FLAG_ID      = 8'h02;
   localparam logic [7:0]  MAGIC_RESET  = 8'h00;

   typedef enum logic [1:0] {
      EV_HDR_BYTE = 2'd0,
      EV_HDR_DONE = 2'd1,
      EV_OPT_BYTE = 2'd2,
      EV_PAYLOAD  = 2'd3
   } event_type;

   typedef struct packed {
      event_type    event_res;
      logic [7:0]   data_byte;
      logic [15:0]  frame_size;
      logic [23:0]  frame_type;
      logic         has_key;
      logic [31:0]  order_key;
      logic         has_msg_id;
      logic [63:0]  msg_id;
      logic         magic_error;
      logic         short_frame;
      logic         frame_end;
   } result_type;

endpackage

### rtl/phd_in_stage.sv
`timescale 1ns / 1ps
module phd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       req_stall,
   output logic       s1_valid,
   output logic [7:0] s1_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign valid_in  = take || (valid_ff && !advance);
   assign s1_valid  = valid_ff;
   assign s1_byte   = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

### rtl/phd_parse.sv
`timescale 1ns / 1ps
module phd_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [7:0]          csr_magic_byte,
   input  logic                advance,
   input  logic [7:0]          rx_byte,
   output phd_pkg::result_type result
);
   import phd_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] size_ff, size_in;
   logic [23:0] type_ff, type_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] id_ff, id_in;
   logic        bad_ff, bad_in;
   logic [7:0]  magic_ff;

   logic        first;
   logic [16:0] next;
   logic        k_bit, i_bit;
   logic [3:0]  optlen;
   logic [15:0] idstart;
   logic        hdr_known;
   logic        end_flag;
   event_type   ev;

   assign first     = (pos_ff == 16'd0);
   assign next      = {1'b0, pos_ff} + 17'd1;
   assign hdr_known = (pos_ff >= HDR_LAST);
   assign flags_in  = first ? 8'd0 : ((pos_ff == HDR_LAST) ? rx_byte : flags_ff);

   always_comb begin
      size_in  = first ? 16'd0 : size_ff;
      type_in  = first ? 24'd0 : type_ff;
      key_in   = first ? 32'd0 : key_ff;
      id_in    = first ? 64'd0 : id_ff;
      bad_in   = first ? 1'b0  : bad_ff;
      end_flag = 1'b0;
      ev       = EV_HDR_BYTE;
      if (pos_ff < HDR_LAST) begin
         if (pos_ff < MAGIC_END) begin
            bad_in = bad_in | (rx_byte != magic_ff);
         end else if (pos_ff < SIZE_END) begin
            size_in = {size_in[7:0], rx_byte};
         end else begin
            type_in = {type_in[15:0], rx_byte};
         end
      end else if (pos_ff == HDR_LAST) begin
         ev       = EV_HDR_DONE;
         end_flag = (size_in <= HDR_LEN);
      end else begin
         if (pos_ff < HDR_LEN + 16'(optlen)) begin
            ev = EV_OPT_BYTE;
            if (pos_ff < idstart) begin
               key_in = {key_in[23:0], rx_byte};
            end else begin
               id_in = {id_in[55:0], rx_byte};
            end
         end else begin
            ev = EV_PAYLOAD;
         end
         end_flag = (next >= {1'b0, size_in});
      end
      pos_in = end_flag ? 16'd0 : next[15:0];
   end

   // flags as they stand after this byte
   assign k_bit   = (flags_in & FLAG_KEY) != 8'd0;
   assign i_bit   = (flags_in & FLAG_ID) != 8'd0;
   assign optlen  = (k_bit ? KEY_BYTES : 4'd0) + (i_bit ? ID_BYTES : 4'd0);
   assign idstart = HDR_LEN + (k_bit ? 16'(KEY_BYTES) : 16'd0);

   always_comb begin
      result.event_res   = ev;
      result.data_byte   = rx_byte;
      result.frame_size  = hdr_known ? size_in : 16'd0;
      result.frame_type  = hdr_known ? type_in : 24'd0;
      result.has_key     = hdr_known && k_bit;
      result.has_msg_id  = hdr_known && i_bit;
      result.order_key   = (hdr_known && k_bit &&
                            next >= {1'b0, HDR_LEN + 16'(KEY_BYTES)}) ? key_in : 32'd0;
      result.msg_id      = (hdr_known && i_bit &&
                            next >= {1'b0, idstart + 16'(ID_BYTES)}) ? id_in : 64'd0;
      result.magic_error = bad_in;
      result.short_frame = hdr_known && (size_in < HDR_LEN + 16'(optlen));
      result.frame_end   = end_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 16'd0;
         size_ff  <= 16'd0;
         type_ff  <= 24'd0;
         flags_ff <= 8'd0;
         key_ff   <= 32'd0;
         id_ff    <= 64'd0;
         bad_ff   <= 1'b0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         size_ff  <= size_in;
         type_ff  <= type_in;
         flags_ff <= flags_in;
         key_ff   <= key_in;
         id_ff    <= id_in;
         bad_ff   <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else if (csr_valid) begin
         magic_ff <= csr_magic_byte;
      end
   end

`ifndef SYNTH
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && result.frame_end |=> pos_ff == 16'd0)
      else $error("frame end did not restart position");

   a_pos_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !result.frame_end |=> pos_ff == $past(pos_ff) + 16'd1)
      else $error("position did not step by one");

   a_hdr_done_pos: assert property (@(posedge clock) disable iff (reset)
      advance && result.event_res == EV_HDR_DONE |-> pos_ff == HDR_LAST)
      else $error("header complete away from flags byte");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pos_ff) && $stable(bad_ff))
      else $error("parser state moved without a transaction");
`endif

endmodule

### rtl/phd_out_stage.sv
`timescale 1ns / 1ps
module phd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                s1_valid,
   input  phd_pkg::result_type result,
   input  logic                rsp_stall,
   output logic                advance,
   output logic                rsp_valid,
   output phd_pkg::result_type rsp_result
);
   import phd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       out_free;

   assign out_free   = !valid_ff || !rsp_stall;
   assign advance    = s1_valid && out_free;
   assign valid_in   = advance || (valid_ff && rsp_stall);
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

endmodule

### rtl/packet_header_deframer.sv
`timescale 1ns / 1ps
// Deframes a length-prefixed byte stream, one byte per transaction, at one byte every
// clock cycle while rsp_stall stays low. Each accepted byte yields one result: the byte
// is held in an input register, parsed against the frame state, and the result lands in
// an output register, so while a result is stalled one more byte can still be
// registered before the input stalls. The magic byte register is written over the csr
// channel, which is always ready; write it only while no transaction is in flight. No
// clearing pass after reset.
module packet_header_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_magic_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_frame_size,
   output logic [23:0] rsp_frame_type,
   output logic        rsp_has_key,
   output logic [31:0] rsp_order_key,
   output logic        rsp_has_msg_id,
   output logic [63:0] rsp_msg_id,
   output logic        rsp_magic_error,
   output logic        rsp_short_frame,
   output logic        rsp_frame_end
);
   import phd_pkg::*;

   logic       advance;
   logic       s1_valid;
   logic [7:0] s1_byte;
   result_type result;
   result_type rsp_result;

   assign csr_ready = 1'b1;

   phd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .req_stall   (req_stall),
      .s1_valid    (s1_valid),
      .s1_byte     (s1_byte)
   );

   phd_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid && csr_ready),
      .csr_magic_byte (csr_magic_byte),
      .advance        (advance),
      .rx_byte        (s1_byte),
      .result         (result)
   );

   phd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_event_res   = rsp_result.event_res;
   assign rsp_data_byte   = rsp_result.data_byte;
   assign rsp_frame_size  = rsp_result.frame_size;
   assign rsp_frame_type  = rsp_result.frame_type;
   assign rsp_has_key     = rsp_result.has_key;
   assign rsp_order_key   = rsp_result.order_key;
   assign rsp_has_msg_id  = rsp_result.has_msg_id;
   assign rsp_msg_id      = rsp_result.msg_id;
   assign rsp_magic_error = rsp_result.magic_error;
   assign rsp_short_frame = rsp_result.short_frame;
   assign rsp_frame_end   = rsp_result.frame_end;

endmodule
